>>> hdl/sit_pkg.sv
package sit_pkg;

  // Result stream: one flag bit, padded to a whole byte.
  localparam int unsigned OUT_TDATA_W = 8;

  // Bit of the result flag inside the master-side tdata.
  localparam int unsigned CROSS_BIT = 0;

endpackage

>>> hdl/segment_intersection_test.sv
// Segment intersection test: one pair of 2-D segments in, one yes/no flag out.
//
// Slave side (s_axis_*): one transaction carries both segments as eight signed
// coordinates of COORD_WIDTH bits, packed from the lowest bit up. Master side
// (m_axis_*): one transaction carries the flag segments_cross in tdata bit 0.
// The remaining tdata bits are zero.
//
// Pipeline: four register stages, differences, products, cross products,
// and the decision into the output register.
// Throughput: one pair per cycle while the receiver keeps taking results.
// The product stage forms six 2*(COORD_WIDTH+1)-bit signed products side by
// side.
//
// Reset (rst_ni low, asynchronous) empties the pipeline. No pair is in flight
// afterwards, s_axis_tready_o is held low during reset and rises with release.
// When the receiver stalls, every stage holds an item only while the stage
// after it is full. Bubbles close up, and the input side keeps accepting until
// all four stages hold an item. Nothing is dropped or repeated.
module segment_intersection_test #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata, from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata, from bit 0: segments_cross, zero padding
  output logic [sit_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;       // coordinate differences
  localparam int unsigned EW = W + 2;       // differences after negation
  localparam int unsigned PW = 2 * DW;      // products of two differences
  localparam int unsigned CW = PW + 1;      // cross products

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || m_axis_tready_i;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  // refuse transactions while reset is held
  assign s_axis_tready_o = en1 && rst_ni;
  assign m_axis_tvalid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, sign-extend and take the differences
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

  assign ax0 = s_axis_tdata_i[0*W +: W];
  assign ay0 = s_axis_tdata_i[1*W +: W];
  assign ax1 = s_axis_tdata_i[2*W +: W];
  assign ay1 = s_axis_tdata_i[3*W +: W];
  assign bx0 = s_axis_tdata_i[4*W +: W];
  assign by0 = s_axis_tdata_i[5*W +: W];
  assign bx1 = s_axis_tdata_i[6*W +: W];
  assign by1 = s_axis_tdata_i[7*W +: W];

  logic signed [DW-1:0] ux_d, uy_d, vx_d, vy_d, wx_d, wy_d, ex_d, ey_d;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q, ex_q, ey_q;
  logic                 end_eq_d, end_eq1_q;

  always_comb begin
    ux_d     = DW'(ax1) - DW'(ax0);
    uy_d     = DW'(ay1) - DW'(ay0);
    vx_d     = DW'(bx1) - DW'(bx0);
    vy_d     = DW'(by1) - DW'(by0);
    wx_d     = DW'(ax0) - DW'(bx0);
    wy_d     = DW'(ay0) - DW'(by0);
    // first segment's end relative to the second segment's start
    ex_d     = DW'(ax1) - DW'(bx0);
    ey_d     = DW'(ay1) - DW'(by0);
    end_eq_d = (ax1 == bx1) && (ay1 == by1);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ux_q      <= ux_d;
      uy_q      <= uy_d;
      vx_q      <= vx_d;
      vy_q      <= vy_d;
      wx_q      <= wx_d;
      wy_q      <= wy_d;
      ex_q      <= ex_d;
      ey_q      <= ey_d;
      end_eq1_q <= end_eq_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: six products, plus the collinear overlap test alongside
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] p0_d, p1_d, p2_d, p3_d, p4_d, p5_d;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [EW-1:0] pa, pb, pden;
  logic                 upt_d, vpt_d, pts_eq_d, proj_ok_d;
  logic                 upt_q, vpt_q, pts_eq_q, proj_ok_q, end_eq2_q;

  always_comb begin
    p0_d = PW'(ux_q) * PW'(vy_q);
    p1_d = PW'(uy_q) * PW'(vx_q);
    p2_d = PW'(ux_q) * PW'(wy_q);
    p3_d = PW'(uy_q) * PW'(wx_q);
    p4_d = PW'(vx_q) * PW'(wy_q);
    p5_d = PW'(vy_q) * PW'(wx_q);

    upt_d    = (ux_q == '0) && (uy_q == '0);
    vpt_d    = (vx_q == '0) && (vy_q == '0);
    pts_eq_d = (wx_q == '0) && (wy_q == '0);

    // project onto x, or onto y for a vertical second segment
    if (vx_q != '0) begin
      pa   = EW'(wx_q);
      pb   = EW'(ex_q);
      pden = EW'(vx_q);
    end else begin
      pa   = EW'(wy_q);
      pb   = EW'(ey_q);
      pden = EW'(vy_q);
    end
    // flip so the denominator is positive
    if (pden < 0) begin
      pa   = -pa;
      pb   = -pb;
      pden = -pden;
    end
    // interval [min(a,b), max(a,b)] misses [0, den] when both lie beyond it
    proj_ok_d = !(((pa > pden) && (pb > pden)) || ((pa < 0) && (pb < 0)));
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p0_q      <= p0_d;
      p1_q      <= p1_d;
      p2_q      <= p2_d;
      p3_q      <= p3_d;
      p4_q      <= p4_d;
      p5_q      <= p5_d;
      upt_q     <= upt_d;
      vpt_q     <= vpt_d;
      pts_eq_q  <= pts_eq_d;
      proj_ok_q <= proj_ok_d;
      end_eq2_q <= end_eq1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: cross products D = u x v, Cu = u x w, Cv = v x w
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] d_q, cu_q, cv_q;
  logic                 upt3_q, vpt3_q, pts_eq3_q, proj_ok3_q, end_eq3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      d_q        <= CW'(p0_q) - CW'(p1_q);
      cu_q       <= CW'(p2_q) - CW'(p3_q);
      cv_q       <= CW'(p4_q) - CW'(p5_q);
      upt3_q     <= upt_q;
      vpt3_q     <= vpt_q;
      pts_eq3_q  <= pts_eq_q;
      proj_ok3_q <= proj_ok_q;
      end_eq3_q  <= end_eq2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: decide. Both parameters Cu/D and Cv/D must lie in [0,1]; compare
  // against D on its own side of zero instead of dividing.
  // ---------------------------------------------------------------------------
  logic cross_d, cross_q;

  always_comb begin
    if (end_eq3_q) begin
      cross_d = 1'b0;                          // shared end point
    end else if (d_q == '0) begin
      if ((cu_q != '0) || (cv_q != '0)) begin
        cross_d = 1'b0;                        // parallel, apart
      end else if (upt3_q && vpt3_q) begin
        cross_d = pts_eq3_q;                   // two points
      end else if (upt3_q || vpt3_q) begin
        cross_d = 1'b0;                        // one point
      end else begin
        cross_d = proj_ok3_q;                  // collinear overlap
      end
    end else if (!d_q[CW-1]) begin
      cross_d = (cu_q >= 0) && (cu_q <= d_q) && (cv_q >= 0) && (cv_q <= d_q);
    end else begin
      cross_d = (cu_q <= 0) && (cu_q >= d_q) && (cv_q <= 0) && (cv_q >= d_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno) begin
      cross_q <= cross_d;
    end
  end

  always_comb begin
    m_axis_tdata_o                    = '0;
    m_axis_tdata_o[sit_pkg::CROSS_BIT] = cross_q;
  end

endmodule

>>> hdl/sit_checker.sv
module sit_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_i,
  input logic                             m_axis_tready_i,
  input logic [sit_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_i
);

  // No result may be offered while reset is held.
  a_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_i)
    else $error("result offered during reset");

  // Hold a stalled result until it is taken.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i)
    else $error("result withdrawn while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // Padding above the flag stays zero in every transaction.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> ((m_axis_tdata_i >> (sit_pkg::CROSS_BIT + 1)) == '0))
    else $error("padding bits set in result");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

>>> tb/sv/testbench.sv
module testbench;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned IN_TDATA_W = ((8 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_W      = sit_pkg::OUT_TDATA_W;
  // Edge that accepts a pair to the edge that shows its flag, plus some slack.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Around 2100 pairs, a long hold-off and drains:
  // keep well clear of the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } segment_pair_t;

  // Clock, reset and stimulus are all known from time zero.
  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b1;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  // from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  logic [IN_TDATA_W-1:0]         s_axis_tdata_i  = '0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  // from bit 0: segments_cross, zero padding
  logic [OUT_W-1:0]              m_axis_tdata_o;

  // Flags still owed by the block, oldest first.
  bit          expected_cross_q[$];
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  // Set by a test to ask the receiver for a long hold-off; the receiver
  // takes it over and counts it down itself.
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  segment_intersection_test #(
    .COORD_WIDTH(COORD_W)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Geometry predictor. Differences need 17 bits and the cross products 35, so
  // 64-bit signed arithmetic keeps everything exact.
  // ---------------------------------------------------------------------------
  function automatic bit predict_cross(segment_pair_t p);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint ux, uy, vx, vy, wx, wy;
    longint det, cross_u, cross_v;
    longint proj_a, proj_b, span, lo, hi;
    bit     first_is_point, second_is_point;
    ax0 = p.first_start_x;  ay0 = p.first_start_y;
    ax1 = p.first_end_x;    ay1 = p.first_end_y;
    bx0 = p.second_start_x; by0 = p.second_start_y;
    bx1 = p.second_end_x;   by1 = p.second_end_y;
    ux = ax1 - ax0; uy = ay1 - ay0;
    vx = bx1 - bx0; vy = by1 - by0;
    wx = ax0 - bx0; wy = ay0 - by0;

    // A shared end point rules the pair out before anything else.
    if (ax1 == bx1 && ay1 == by1) return 1'b0;

    det     = ux * vy - uy * vx;
    cross_u = ux * wy - uy * wx;
    cross_v = vx * wy - vy * wx;

    if (det == 0) begin
      // Parallel: only collinear pairs can still meet.
      if (cross_u != 0 || cross_v != 0) return 1'b0;
      first_is_point  = (ux == 0 && uy == 0);
      second_is_point = (vx == 0 && vy == 0);
      if (first_is_point && second_is_point) return (ax0 == bx0 && ay0 == by0);
      if (first_is_point || second_is_point) return 1'b0;
      // Project the first segment onto the second one's parameter, using y
      // when the second segment is vertical.
      if (vx != 0) begin
        proj_a = wx; proj_b = ax1 - bx0; span = vx;
      end else begin
        proj_a = wy; proj_b = ay1 - by0; span = vy;
      end
      if (span < 0) begin
        proj_a = -proj_a; proj_b = -proj_b; span = -span;
      end
      lo = (proj_a < proj_b) ? proj_a : proj_b;
      hi = (proj_a < proj_b) ? proj_b : proj_a;
      return !(lo > span || hi < 0);
    end

    // Both parameters in [0,1], compared without dividing by the determinant.
    if (det < 0) begin
      det = -det; cross_u = -cross_u; cross_v = -cross_v;
    end
    return (cross_v >= 0 && cross_v <= det && cross_u >= 0 && cross_u <= det);
  endfunction

  function automatic segment_pair_t build_pair(int ax0, int ay0, int ax1, int ay1,
                                               int bx0, int by0, int bx1, int by1);
    segment_pair_t p;
    p.first_start_x  = coord_t'(ax0);
    p.first_start_y  = coord_t'(ay0);
    p.first_end_x    = coord_t'(ax1);
    p.first_end_y    = coord_t'(ay1);
    p.second_start_x = coord_t'(bx0);
    p.second_start_y = coord_t'(by0);
    p.second_end_x   = coord_t'(bx1);
    p.second_end_y   = coord_t'(by1);
    return p;
  endfunction

  // Random pair, shaped so that the parallel, collinear, degenerate and
  // shared-point branches are all reached often, not just the general case.
  function automatic segment_pair_t random_pair();
    int v[8];
    int extremes[7];
    int kind, base_x, base_y, dir_x, dir_y, off_x, off_y, t, i;
    extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    kind = $urandom_range(0, 9);
    case (kind)
      3, 4: begin
        // tight grid: many coincidences and parallels
        for (i = 0; i < 8; i++) v[i] = int'($urandom_range(0, 6)) - 3;
      end
      5, 6: begin
        // points on one line; for kind 6 shift the second segment sideways
        base_x = int'($urandom_range(0, 2000)) - 1000;
        base_y = int'($urandom_range(0, 2000)) - 1000;
        dir_x  = int'($urandom_range(0, 8)) - 4;
        dir_y  = int'($urandom_range(0, 8)) - 4;
        off_x  = (kind == 6) ? int'($urandom_range(0, 4)) - 2 : 0;
        off_y  = (kind == 6) ? int'($urandom_range(0, 4)) - 2 : 0;
        for (i = 0; i < 4; i++) begin
          t = int'($urandom_range(0, 20)) - 10;
          v[2*i]   = base_x + t * dir_x + ((i >= 2) ? off_x : 0);
          v[2*i+1] = base_y + t * dir_y + ((i >= 2) ? off_y : 0);
        end
      end
      7: begin
        // copy one end point of the first segment into the second
        for (i = 0; i < 8; i++) v[i] = int'($urandom_range(0, 40)) - 20;
        case ($urandom_range(0, 3))
          0: begin v[4] = v[0]; v[5] = v[1]; end
          1: begin v[6] = v[2]; v[7] = v[3]; end
          2: begin v[4] = v[2]; v[5] = v[3]; end
          default: begin v[6] = v[0]; v[7] = v[1]; end
        endcase
      end
      8: begin
        for (i = 0; i < 8; i++) v[i] = extremes[$urandom_range(0, 6)];
      end
      9: begin
        // collapse one or both segments to a point
        for (i = 0; i < 8; i++) v[i] = int'($urandom_range(0, 8)) - 4;
        t = $urandom_range(0, 2);
        if (t != 1) begin v[2] = v[0]; v[3] = v[1]; end
        if (t != 0) begin v[6] = v[4]; v[7] = v[5]; end
      end
      default: begin
        for (i = 0; i < 8; i++) v[i] = int'($urandom);
      end
    endcase
    return build_pair(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge with tvalid
  // still high, so back-to-back pairs drop valid only for send_idle_pct idles.
  // ---------------------------------------------------------------------------
  task automatic send_pair(segment_pair_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = '0;
    s_axis_tdata_i[0*COORD_W +: COORD_W] = p.first_start_x;
    s_axis_tdata_i[1*COORD_W +: COORD_W] = p.first_start_y;
    s_axis_tdata_i[2*COORD_W +: COORD_W] = p.first_end_x;
    s_axis_tdata_i[3*COORD_W +: COORD_W] = p.first_end_y;
    s_axis_tdata_i[4*COORD_W +: COORD_W] = p.second_start_x;
    s_axis_tdata_i[5*COORD_W +: COORD_W] = p.second_start_y;
    s_axis_tdata_i[6*COORD_W +: COORD_W] = p.second_end_x;
    s_axis_tdata_i[7*COORD_W +: COORD_W] = p.second_end_y;
    // Hold the pair until a rising edge sees the handshake.
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_cross_q = {expected_cross_q, predict_cross(p)};
    @(negedge clk_i);
  endtask

  // Drop valid, wait until every owed flag has arrived, then let the
  // pipeline settle so that any stray result still shows up.
  task automatic wait_for_results();
    s_axis_tvalid_i = 1'b0;
    while (expected_cross_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pair(build_pair(0, 0, 0, 0, 0, 0, 0, 0));               // all zero
    send_pair(build_pair(0, 0, 5, 5, 5, 0, 5, 5));               // shared end point
    send_pair(build_pair(0, 0, 10, 10, 0, 10, 10, 0));           // plain crossing
    send_pair(build_pair(0, 0, 1, 1, 5, 0, 6, -3));              // miss, not parallel
    send_pair(build_pair(0, 0, 4, 2, 0, 0, -3, 5));              // shared start point
    send_pair(build_pair(0, 0, 10, 0, 5, 0, 5, 7));              // T junction
    send_pair(build_pair(0, 0, 10, 0, 0, 1, 10, 1));             // parallel, apart
    send_pair(build_pair(3, 3, 3, 3, 3, 3, 3, 3));               // two equal points
    send_pair(build_pair(3, 3, 3, 3, 4, 4, 4, 4));               // two distinct points
    send_pair(build_pair(2, 0, 2, 0, 0, 0, 5, 0));               // first is a point
    send_pair(build_pair(0, 0, 5, 0, 2, 0, 2, 0));               // second is a point
    send_pair(build_pair(0, 0, 6, 0, 3, 0, 9, 0));               // collinear overlap
    send_pair(build_pair(0, 0, 2, 0, 3, 0, 9, 0));               // collinear gap
    send_pair(build_pair(0, 0, 3, 0, 3, 0, 9, 0));               // collinear touch
    send_pair(build_pair(0, 0, 6, 6, 9, 9, 4, 4));               // collinear, reversed
    send_pair(build_pair(0, -2, 0, 1, 0, 0, 0, 5));              // vertical overlap
    send_pair(build_pair(0, -5, 0, -1, 0, 0, 0, 5));             // vertical gap
    send_pair(build_pair(-10, -5, 10, 5, -2, -1, 4, 2));         // collinear, contained
    send_pair(build_pair(-32768, -32768, 32767, 32767,
                         -32768, 32767, 32767, -32768));         // full-range diagonals
    send_pair(build_pair(32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767));           // all maximum
    send_pair(build_pair(-32768, -32768, 32767, -32768,
                         -32768, 32767, 32767, 32767));          // extreme parallels
    send_pair(build_pair(-32768, -32768, 32767, 32766,
                         -32768, -32767, 32767, 32767));         // extreme near miss
    send_pair(build_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0)); // extreme collinear
    wait_for_results();
  endtask

  task automatic test_random_pairs(int unsigned count, int unsigned send_pct,
                                   int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pair(random_pair());
    wait_for_results();
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering
  // pairs, so the pipeline fills and pushes back on the input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 300;
    repeat (80) send_pair(random_pair());
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: change tready at the falling edge only.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready_i = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: compare each master-side transaction with the oldest flag.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_cross_q.size() == 0) begin
        $error("segments_cross: expected none, actual %0d",
               m_axis_tdata_o[sit_pkg::CROSS_BIT]);
        fail_count++;
      end else begin
        if (m_axis_tdata_o[sit_pkg::CROSS_BIT] !== expected_cross_q[0]) begin
          $error("segments_cross: expected %0d, actual %0d",
                 expected_cross_q[0], m_axis_tdata_o[sit_pkg::CROSS_BIT]);
          fail_count++;
        end
        expected_cross_q.pop_front();
      end
      if ((m_axis_tdata_o & ~(OUT_W'(1) << sit_pkg::CROSS_BIT)) !== '0) begin
        $error("tdata padding: expected 0, actual %0h", m_axis_tdata_o);
        fail_count++;
      end
    end
  end

  // Watchdog: end the run if the cycle count runs past the limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    // Assert reset at the first falling edge and release it at a falling edge.
    @(negedge clk_i);
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_pairs(700, 13, 46);
    test_random_pairs(700, 46, 13);
    test_backpressure();
    test_random_pairs(600, 0, 0);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
